// ----- design/assert_macros.svh -----
// Assertion helpers for the checker file wnm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- design/wnm_pkg.sv -----
// ============================================================================
// wnm_pkg
// Shared types and constants of the wildcard name matcher.
// ============================================================================
`default_nettype none

package wnm_pkg;

    // Number of pattern characters held by the cell row.
    localparam int PATTERN_DEPTH = 32;

    // Pattern wildcards.
    localparam logic [7:0] CH_ONE = 8'h3F;  // question mark: any one character
    localparam logic [7:0] CH_ANY = 8'h2A;  // asterisk: any run of characters

    // Item operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NAME = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // One input transfer.
    typedef struct packed {
        logic       operation;
        logic [7:0] character;
        logic       last;
    } item_t;

    // One result transfer.
    typedef struct packed {
        logic       matched;
        logic [1:0] status;
    } result_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic       load;     // a pattern character is being transferred
        logic       name;     // a name character is being transferred
        logic       restart;  // the load opens a new pattern
        logic       fresh;    // the name character is the first of its name
        logic [7:0] ch;
    } ctl_t;

    // Signals handed from one cell to its right-hand neighbor.
    typedef struct packed {
        logic valid;  // left cell holds a character of the current pattern
        logic start;  // position is live at the start of a name
        logic carry;  // position is reached by the current name character
    } link_t;

endpackage

`default_nettype wire

// ----- design/wildcard_name_matcher.sv -----
// ============================================================================
// wildcard_name_matcher
// Matches a streamed name against a loaded wildcard pattern.
// ============================================================================
// Usage:
//   item channel (item_valid, item_stall, item): with OP_LOAD each transfer
//   appends one pattern character. A load that follows a closed pattern
//   starts a new one. With OP_NAME each transfer gives one name character,
//   and the first name character closes the pattern. A load abandons a name.
//   result channel (result_valid, result_stall, result): one transfer per
//   name, after the character marked last. It carries matched and a status:
//   ok, empty pattern, or pattern longer than PATTERN_DEPTH characters.
//   Throughput: one item per cycle while item_stall is low. Every pattern
//   position is a cell of a row. All cells update in the same cycle, and
//   the star closure ripples through the row as one chain, which sets the
//   clock period. The result shows in the cycle after the last name character.
//   Reset empties the pattern and drops any name in progress.
//   When the receiver stalls, the result is held in the output register and
//   item_stall rises only while that register is full and stalled.
// ============================================================================
`default_nettype none

module wildcard_name_matcher (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire wnm_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output wnm_pkg::result_t      result
);

    localparam int D = wnm_pkg::PATTERN_DEPTH;

    logic accept;
    logic done_reg;
    logic done_next;
    logic ovf_reg;
    logic ovf_next;
    logic prog_reg;
    logic prog_next;
    logic out_valid_reg;
    logic out_valid_next;
    wnm_pkg::result_t out_reg;
    wnm_pkg::result_t out_next;

    wnm_pkg::ctl_t  ctl;
    wnm_pkg::link_t link [0:D];
    logic [D-1:0]   hit;
    logic           matched;
    logic           produce;

    // Accept while the output register can take a result
    assign item_stall   = out_valid_reg & result_stall;
    assign accept       = item_valid & ~item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Broadcast the command to the row
    always_comb
    begin
        ctl.load    = accept & (item.operation == wnm_pkg::OP_LOAD);
        ctl.name    = accept & (item.operation == wnm_pkg::OP_NAME);
        ctl.restart = ctl.load & done_reg;
        ctl.fresh   = ~prog_reg;
        ctl.ch      = item.character;
    end

    // Feed the head of the row: always room, position zero starts live
    always_comb
    begin
        link[0].valid = 1'b1;
        link[0].start = 1'b1;
        link[0].carry = 1'b0;
    end

    // Cell row
    for (genvar i = 0; i < D; i++)
    begin : g_cell
        wnm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .hit      (hit[i])
        );
    end

    // Collect the live flag at the pattern's end position
    assign matched = (|hit) | (link[D].carry & link[D].valid);
    assign produce = ctl.name & item.last;

    // Pattern and name bookkeeping
    always_comb
    begin
        done_next = done_reg;
        ovf_next  = ovf_reg;
        prog_next = prog_reg;
        if (ctl.load)
        begin
            done_next = item.last;
            ovf_next  = (ovf_reg & ~done_reg) | link[D].valid;
            prog_next = 1'b0;
        end
        else if (ctl.name)
        begin
            done_next = 1'b1;
            prog_next = ~item.last;
        end
    end

    // Form the result and hold it while stalled
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg & result_stall;
        if (produce)
        begin
            out_valid_next = 1'b1;
            priority if (!link[1].valid)
            begin
                out_next.matched = 1'b0;
                out_next.status  = wnm_pkg::STATUS_EMPTY;
            end
            else if (ovf_reg)
            begin
                out_next.matched = 1'b0;
                out_next.status  = wnm_pkg::STATUS_OVERFLOW;
            end
            else
            begin
                out_next.matched = matched;
                out_next.status  = wnm_pkg::STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            prog_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            ovf_reg       <= ovf_next;
            prog_reg      <= prog_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

// ----- design/wnm_cell.sv -----
// ============================================================================
// wnm_cell
// One pattern position: holds its character, its valid flag, its live flag
// and its start-of-name flag, and passes reach and closure to the right.
// ============================================================================
`default_nettype none

module wnm_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire wnm_pkg::ctl_t  ctl,
    input  wire wnm_pkg::link_t link_in,
    output wnm_pkg::link_t      link_out,
    output logic                hit
);

    logic [7:0] char_reg;
    logic       valid_reg;
    logic       valid_next;
    logic       live_reg;
    logic       start_reg;

    logic eff_valid;
    logic is_star;
    logic load_here;
    logic live_cur;
    logic active;
    logic stay;
    logic step;
    logic closed;

    // Decode the stored character and pick the live flag for this character
    always_comb
    begin
        eff_valid = valid_reg & ~ctl.restart;
        is_star   = (char_reg == wnm_pkg::CH_ANY);
        load_here = ctl.load & link_in.valid & ~eff_valid;
        live_cur  = ctl.fresh ? start_reg : live_reg;
        active    = valid_reg & live_cur;
        stay      = active & is_star;
        step      = active & ~is_star &
                    ((char_reg == wnm_pkg::CH_ONE) | (char_reg == ctl.ch));
        closed    = link_in.carry | stay;
    end

    // Hand reach, closure and pattern extent to the neighbor
    always_comb
    begin
        link_out.valid = eff_valid;
        link_out.start = start_reg & is_star;
        link_out.carry = valid_reg & ((closed & is_star) | step);
        // This is the end position of the pattern when the left cell is the last one
        hit            = link_in.carry & ~valid_reg & link_in.valid;
    end

    // Grow or restart the pattern on loads, hold on names
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.load)
        begin
            valid_next = eff_valid | load_here;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            live_reg  <= 1'b0;
            start_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load_here)
            begin
                start_reg <= link_in.start;
            end
            if (ctl.name)
            begin
                live_reg <= closed;
            end
        end
    end

    // Capture the pattern character
    always_ff @(posedge clk)
    begin
        if (load_here)
        begin
            char_reg <= ctl.ch;
        end
    end

endmodule

`default_nettype wire

// ----- design/wnm_checker.sv -----
// ============================================================================
// wnm_checker
// Port-level checks of the wildcard name matcher, bound to the top level.
// ============================================================================
`default_nettype none
`include "assert_macros.svh"

module wnm_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_stall,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire wnm_pkg::result_t result
);

    // Hold a stalled result
    `ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid)
    `ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(result))

    // Stall input only when the output register is blocked
    `ASSERT_SAME(a_stall_cause, item_stall, result_valid && result_stall)

    // Report only defined status codes
    `ASSERT_SAME(a_status_code, result_valid, result.status <= wnm_pkg::STATUS_OVERFLOW)

    // Never flag a match on an error status
    `ASSERT_SAME(a_error_no_match, result_valid && result.status != wnm_pkg::STATUS_OK, !result.matched)

endmodule

bind wildcard_name_matcher wnm_checker u_wnm_checker (.*);

`default_nettype wire
